@@ rtl/core/rlb_pkg.sv @@
// Shared types and constants for the RGBA layer blend core.
// Holds blend mode codes, register indexes and the lane stage-enable group.
// No dependencies.
package rlb_pkg;

	// Default channel width; ports and lanes follow the module parameter
	localparam int unsigned CHANNEL_BITS_DEF = 8;

	// Number of color lanes (red, green, blue)
	localparam int unsigned LANES = 3;

	// Opacity is Q1.8 held in nine bits, 256 means one
	localparam int unsigned OPACITY_BITS = 9;
	localparam int unsigned OPACITY_FRAC = 8;
	localparam logic [OPACITY_BITS-1:0] OPACITY_ONE = 9'd256;

	// Configuration port
	localparam int unsigned CFG_INDEX_BITS = 2;
	localparam int unsigned CFG_DATA_BITS  = 9;
	localparam int unsigned MODE_BITS      = 3;

	localparam logic [CFG_INDEX_BITS-1:0] REG_BLEND_MODE = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_OPACITY    = 2'd1;

	// Blend mode codes; codes above add behave as normal
	typedef enum logic [MODE_BITS-1:0] {
		MODE_NORMAL   = 3'd0,
		MODE_MULTIPLY = 3'd1,
		MODE_SCREEN   = 3'd2,
		MODE_OVERLAY  = 3'd3,
		MODE_ADD      = 3'd4
	} mode_t;

	// Per-stage load enables that the top level hands to every lane
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
	} stage_en_t;

endpackage

@@ rtl/core/rlb_in_if.sv @@
// Input channel of the RGBA layer blend core: one base RGBA and one overlay RGB pixel.
// Depends on rlb_pkg for the default channel width.
interface rlb_in_if #(
	parameter int unsigned CHANNEL_BITS = rlb_pkg::CHANNEL_BITS_DEF
);
	logic                    valid;
	logic                    ready;
	logic [CHANNEL_BITS-1:0] base_red;
	logic [CHANNEL_BITS-1:0] base_green;
	logic [CHANNEL_BITS-1:0] base_blue;
	logic [CHANNEL_BITS-1:0] base_alpha;
	logic [CHANNEL_BITS-1:0] over_red;
	logic [CHANNEL_BITS-1:0] over_green;
	logic [CHANNEL_BITS-1:0] over_blue;

	modport source (
		output valid, base_red, base_green, base_blue, base_alpha,
		output over_red, over_green, over_blue,
		input  ready
	);

	modport sink (
		input  valid, base_red, base_green, base_blue, base_alpha,
		input  over_red, over_green, over_blue,
		output ready
	);
endinterface

@@ rtl/core/rlb_out_if.sv @@
// Output channel of the RGBA layer blend core: one blended RGBA pixel.
// Depends on rlb_pkg for the default channel width.
interface rlb_out_if #(
	parameter int unsigned CHANNEL_BITS = rlb_pkg::CHANNEL_BITS_DEF
);
	logic                    valid;
	logic                    ready;
	logic [CHANNEL_BITS-1:0] out_red;
	logic [CHANNEL_BITS-1:0] out_green;
	logic [CHANNEL_BITS-1:0] out_blue;
	logic [CHANNEL_BITS-1:0] out_alpha;

	modport source (
		output valid, out_red, out_green, out_blue, out_alpha,
		input  ready
	);

	modport sink (
		input  valid, out_red, out_green, out_blue, out_alpha,
		output ready
	);
endinterface

@@ rtl/core/rlb_lane.sv @@
// One color lane of the blend core: mode blend, divide by channel max, opacity mix.
// Three pipeline stages, loaded by the stage enables from the top level.
// Depends on rlb_pkg.
module rlb_lane #(
	parameter int unsigned CHANNEL_BITS = rlb_pkg::CHANNEL_BITS_DEF
) (
	input  logic                                clk,
	input  rlb_pkg::stage_en_t                  stage_en,
	input  rlb_pkg::mode_t                      mode,
	input  logic [rlb_pkg::OPACITY_BITS-1:0]    opacity,
	input  logic [CHANNEL_BITS-1:0]             base,
	input  logic [CHANNEL_BITS-1:0]             over,
	output logic [CHANNEL_BITS-1:0]             result
);

	localparam int unsigned W  = CHANNEL_BITS;
	localparam int unsigned PW = 2 * W + 1;
	localparam int unsigned OB = rlb_pkg::OPACITY_BITS;
	localparam int unsigned MW = W + OB + 2;
	localparam logic [W-1:0] CH_MAX = {W{1'b1}};

	// Stage 1: operand select and product
	logic [W-1:0]  base_inv;
	logic [W-1:0]  over_inv;
	logic [W:0]    sum_add;
	logic [W:0]    fac_a;
	logic [W-1:0]  fac_b;
	logic          inv_sel;
	logic          use_prod;
	logic [W-1:0]  direct;
	logic [PW-1:0] prod;

	logic [PW-1:0] prod_s1;
	logic          inv_s1;
	logic          use_prod_s1;
	logic [W-1:0]  direct_s1;
	logic [W-1:0]  base_s1;

	always_comb begin
		base_inv = ~base;
		over_inv = ~over;
		sum_add  = {1'b0, base} + {1'b0, over};
		fac_a    = '0;
		fac_b    = '0;
		inv_sel  = 1'b0;
		use_prod = 1'b0;
		direct   = over;
		case (mode)
			rlb_pkg::MODE_MULTIPLY: begin
				fac_a    = {1'b0, base};
				fac_b    = over;
				use_prod = 1'b1;
			end
			rlb_pkg::MODE_SCREEN: begin
				fac_a    = {1'b0, base_inv};
				fac_b    = over_inv;
				inv_sel  = 1'b1;
				use_prod = 1'b1;
			end
			rlb_pkg::MODE_OVERLAY: begin
				// base below half when its top bit is clear
				use_prod = 1'b1;
				if (!base[W-1]) begin
					fac_a = {base, 1'b0};
					fac_b = over;
				end else begin
					fac_a   = {base_inv, 1'b0};
					fac_b   = over_inv;
					inv_sel = 1'b1;
				end
			end
			rlb_pkg::MODE_ADD: begin
				direct = sum_add[W] ? CH_MAX : sum_add[W-1:0];
			end
			default: begin
				direct = over;
			end
		endcase
	end

	assign prod = fac_a * fac_b;

	always_ff @(posedge clk) begin
		if (stage_en.en_s1) begin
			prod_s1     <= prod;
			inv_s1      <= inv_sel;
			use_prod_s1 <= use_prod;
			direct_s1   <= direct;
			base_s1     <= base;
		end
	end

	// Stage 2: floor divide by 2^W-1 through folded remainders, then select
	logic [W:0]   quo_hi;
	logic [W+1:0] rem_a;
	logic [1:0]   quo_mid;
	logic [W:0]   rem_b;
	logic         rem_fix;
	logic [W:0]   quo;
	logic [W-1:0] blend;

	logic [W-1:0] blend_s2;
	logic [W-1:0] base_s2;

	always_comb begin
		quo_hi  = prod_s1[PW-1:W];
		rem_a   = {2'b00, prod_s1[W-1:0]} + {1'b0, quo_hi};
		quo_mid = rem_a[W+1:W];
		rem_b   = {1'b0, rem_a[W-1:0]} + {{(W-1){1'b0}}, quo_mid};
		rem_fix = (rem_b >= {1'b0, CH_MAX});
		quo     = quo_hi + {{(W-1){1'b0}}, quo_mid} + {{W{1'b0}}, rem_fix};
		if (!use_prod_s1) begin
			blend = direct_s1;
		end else if (inv_s1) begin
			blend = CH_MAX - quo[W-1:0];
		end else begin
			blend = quo[W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en.en_s2) begin
			blend_s2 <= blend;
			base_s2  <= base_s1;
		end
	end

	// Stage 3: base + floor((blend - base) * opacity / 256), clamped
	logic signed [W:0]    diff;
	logic signed [OB:0]   op_sgn;
	logic signed [MW-1:0] scaled;
	logic signed [MW-1:0] mixed;
	logic [W-1:0]         mix_sat;

	logic [W-1:0] result_s3;

	assign diff   = $signed({1'b0, blend_s2}) - $signed({1'b0, base_s2});
	assign op_sgn = $signed({1'b0, opacity});
	assign scaled = diff * op_sgn;
	assign mixed  = $signed({{(OB + 2){1'b0}}, base_s2}) + (scaled >>> rlb_pkg::OPACITY_FRAC);

	always_comb begin
		if (mixed < 0) begin
			mix_sat = '0;
		end else if (mixed > $signed({{(OB + 2){1'b0}}, CH_MAX})) begin
			mix_sat = CH_MAX;
		end else begin
			mix_sat = mixed[W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en.en_s3) begin
			result_s3 <= mix_sat;
		end
	end

	assign result = result_s3;

endmodule

@@ rtl/core/rgba_layer_blend_core.sv @@
// Top level of the RGBA layer blend core: config registers, valid pipeline,
// three color lanes and the output word assembly.
// Depends on rlb_pkg, rlb_in_if, rlb_out_if and rlb_lane.

// Blends an overlay RGB pixel onto a base RGBA pixel by the selected mode
// (normal, multiply, screen, overlay, saturating add), then mixes the result
// with the base by opacity (Q1.8, 256 is fully applied; larger values act as
// 256). Base alpha passes through. The core takes one pixel every cycle while
// the output is not stalled and carries it through the three-stage lane
// pipeline (operand product, divide by channel max, opacity mix), and the
// last stage is the output register. A stalled output holds its word while
// empty stages upstream keep filling. Write blend_mode and opacity only while
// no pixel is in flight; mode codes 5 to 7 act as normal.
module rgba_layer_blend_core #(
	parameter int unsigned CHANNEL_BITS = rlb_pkg::CHANNEL_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [rlb_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [rlb_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	rlb_in_if.sink                               pix_in,
	rlb_out_if.source                            pix_out
);

	localparam int unsigned W = CHANNEL_BITS;

	// Configuration registers
	rlb_pkg::mode_t                   blend_mode_q;
	logic [rlb_pkg::OPACITY_BITS-1:0] opacity_q;
	logic [rlb_pkg::OPACITY_BITS-1:0] opacity_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_mode_q <= rlb_pkg::MODE_NORMAL;
			opacity_q    <= rlb_pkg::OPACITY_ONE;
		end else if (cfg_we) begin
			case (cfg_index)
				rlb_pkg::REG_BLEND_MODE: begin
					blend_mode_q <= rlb_pkg::mode_t'(cfg_data[rlb_pkg::MODE_BITS-1:0]);
				end
				rlb_pkg::REG_OPACITY: begin
					opacity_q <= cfg_data[rlb_pkg::OPACITY_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Clamp opacity above one down to one
	assign opacity_eff = opacity_q[rlb_pkg::OPACITY_BITS-1] ? rlb_pkg::OPACITY_ONE : opacity_q;

	// Valid pipeline: a stage loads when it is empty or the next one loads
	rlb_pkg::stage_en_t stage_en;
	logic               valid_s1;
	logic               valid_s2;
	logic               valid_s3;

	assign stage_en.en_s3 = !valid_s3 || pix_out.ready;
	assign stage_en.en_s2 = !valid_s2 || stage_en.en_s3;
	assign stage_en.en_s1 = !valid_s1 || stage_en.en_s2;

	assign pix_in.ready = stage_en.en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (stage_en.en_s1) begin
				valid_s1 <= pix_in.valid;
			end
			if (stage_en.en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (stage_en.en_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Carry alpha alongside the lanes
	logic [W-1:0] alpha_s1;
	logic [W-1:0] alpha_s2;
	logic [W-1:0] alpha_s3;

	always_ff @(posedge clk) begin
		if (stage_en.en_s1) begin
			alpha_s1 <= pix_in.base_alpha;
		end
		if (stage_en.en_s2) begin
			alpha_s2 <= alpha_s1;
		end
		if (stage_en.en_s3) begin
			alpha_s3 <= alpha_s2;
		end
	end

	// Color lanes
	logic [W-1:0] lane_base   [rlb_pkg::LANES];
	logic [W-1:0] lane_over   [rlb_pkg::LANES];
	logic [W-1:0] lane_result [rlb_pkg::LANES];

	assign lane_base[0] = pix_in.base_red;
	assign lane_base[1] = pix_in.base_green;
	assign lane_base[2] = pix_in.base_blue;
	assign lane_over[0] = pix_in.over_red;
	assign lane_over[1] = pix_in.over_green;
	assign lane_over[2] = pix_in.over_blue;

	for (genvar ln = 0; ln < rlb_pkg::LANES; ln++) begin : g_lane
		rlb_lane #(
			.CHANNEL_BITS (CHANNEL_BITS)
		) u_lane (
			.clk      (clk),
			.stage_en (stage_en),
			.mode     (blend_mode_q),
			.opacity  (opacity_eff),
			.base     (lane_base[ln]),
			.over     (lane_over[ln]),
			.result   (lane_result[ln])
		);
	end

	// Assemble the output word
	assign pix_out.valid     = valid_s3;
	assign pix_out.out_red   = lane_result[0];
	assign pix_out.out_green = lane_result[1];
	assign pix_out.out_blue  = lane_result[2];
	assign pix_out.out_alpha = alpha_s3;

endmodule

@@ sim/rgba_layer_blend_core_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for rgba_layer_blend_core: directed and random pixel words
// are checked against an in-bench blend predictor, with random idling on both channels.
// Depends on rlb_pkg, rlb_in_if, rlb_out_if and the core RTL.
module rgba_layer_blend_core_test;
	import rlb_pkg::*;

	localparam int unsigned CB          = CHANNEL_BITS_DEF;
	localparam longint unsigned CH_MAX  = (64'd1 << CB) - 1;
	localparam int unsigned PIPE_DEPTH  = 3;
	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES = 60;
	localparam int unsigned HOLD_WORDS  = 24;
	localparam int unsigned PHASES      = 13;
	localparam int unsigned PHASE_WORDS = 46;
	localparam int unsigned MAX_IDLE    = 6;

	// Indexes with no register behind them, and mode codes above add
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 2'd3;
	localparam logic [MODE_BITS-1:0] MODE_SPARE_5 = 3'd5;
	localparam logic [MODE_BITS-1:0] MODE_SPARE_6 = 3'd6;
	localparam logic [MODE_BITS-1:0] MODE_SPARE_7 = 3'd7;
	localparam logic [OPACITY_BITS-1:0] OPACITY_ALL_ONES = '1;

	typedef struct packed {
		logic [CB-1:0] base_red, base_green, base_blue, base_alpha;
		logic [CB-1:0] over_red, over_green, over_blue;
	} src_pixel_t;

	typedef struct packed {
		logic [CB-1:0] red, green, blue, alpha;
	} blend_pixel_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	rlb_in_if  #(.CHANNEL_BITS(CB)) pix_in ();
	rlb_out_if #(.CHANNEL_BITS(CB)) pix_out ();

	// Bench copy of the two registers
	logic [MODE_BITS-1:0]    mode_copy;
	logic [OPACITY_BITS-1:0] opacity_copy;

	blend_pixel_t predicted_pixels[$];
	int unsigned  mismatches;
	bit           sender_idles;
	bit           receiver_stalls;
	int unsigned  hold_request;
	int unsigned  stall_left;
	int unsigned  quiet_cycles;

	rgba_layer_blend_core #(.CHANNEL_BITS(CB)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_in    (pix_in),
		.pix_out   (pix_out)
	);

	always #5 clk = ~clk;

	// Blend one channel by the current mode
	function automatic longint unsigned blend_lane(longint unsigned b, longint unsigned o);
		longint unsigned r;
		case (mode_copy)
			MODE_MULTIPLY: r = b * o / CH_MAX;
			MODE_SCREEN:   r = CH_MAX - (CH_MAX - b) * (CH_MAX - o) / CH_MAX;
			MODE_OVERLAY: begin
				if (2 * b < CH_MAX)
					r = 2 * b * o / CH_MAX;
				else
					r = CH_MAX - 2 * (CH_MAX - b) * (CH_MAX - o) / CH_MAX;
			end
			MODE_ADD:      r = (b + o > CH_MAX) ? CH_MAX : b + o;
			default:       r = o;
		endcase
		return r;
	endfunction

	// Mix the blended channel with the base by opacity, clamped to one
	function automatic logic [CB-1:0] mix_lane(longint unsigned b, longint unsigned r);
		longint unsigned op;
		longint unsigned v;
		op = (opacity_copy > OPACITY_ONE) ? OPACITY_ONE : opacity_copy;
		v = (b * (OPACITY_ONE - op) + r * op) >> OPACITY_FRAC;
		if (v > CH_MAX)
			v = CH_MAX;
		return CB'(v);
	endfunction

	function automatic blend_pixel_t blend_pixel(src_pixel_t px);
		blend_pixel_t res;
		res.red   = mix_lane(px.base_red,   blend_lane(px.base_red,   px.over_red));
		res.green = mix_lane(px.base_green, blend_lane(px.base_green, px.over_green));
		res.blue  = mix_lane(px.base_blue,  blend_lane(px.base_blue,  px.over_blue));
		res.alpha = px.base_alpha;
		return res;
	endfunction

	// Lean toward the extremes and the overlay threshold
	function automatic logic [CB-1:0] rand_channel();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return CB'(CH_MAX / 2 + $urandom_range(0, 1));
			default: return CB'($urandom());
		endcase
	endfunction

	function automatic src_pixel_t random_pixel();
		src_pixel_t px;
		px.base_red   = rand_channel();
		px.base_green = rand_channel();
		px.base_blue  = rand_channel();
		px.base_alpha = rand_channel();
		px.over_red   = rand_channel();
		px.over_green = rand_channel();
		px.over_blue  = rand_channel();
		return px;
	endfunction

	function automatic void compare_field(string name, logic [CB-1:0] want, logic [CB-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Offer one word after a random gap and hold it until accepted
	task automatic send_pixel(input src_pixel_t px);
		int unsigned gap;
		gap = sender_idles ? $urandom_range(0, MAX_IDLE) : 0;
		if (gap != 0) begin
			pix_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_in.valid      <= 1'b1;
		pix_in.base_red   <= px.base_red;
		pix_in.base_green <= px.base_green;
		pix_in.base_blue  <= px.base_blue;
		pix_in.base_alpha <= px.base_alpha;
		pix_in.over_red   <= px.over_red;
		pix_in.over_green <= px.over_green;
		pix_in.over_blue  <= px.over_blue;
		do @(posedge clk); while (!pix_in.ready);
		predicted_pixels.push_back(blend_pixel(px));
	endtask

	// Drop valid, drain the pipe and let it go quiet
	task automatic settle();
		pix_in.valid <= 1'b0;
		while (predicted_pixels.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
				 input logic [CFG_DATA_BITS-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_BLEND_MODE: mode_copy = data[MODE_BITS-1:0];
			REG_OPACITY:    opacity_copy = data;
			default: ;
		endcase
	endtask

	// Two words covering zero, full scale and both sides of the overlay split
	task automatic send_probes();
		send_pixel('{8'd0, 8'd255, 8'd127, 8'd0, 8'd255, 8'd0, 8'd255});
		send_pixel('{8'd128, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd128});
	endtask

	task automatic test_reset_values();
		send_probes();
		settle();
	endtask

	task automatic test_blend_modes();
		logic [MODE_BITS-1:0] every_mode[8];
		every_mode = '{MODE_NORMAL, MODE_MULTIPLY, MODE_SCREEN, MODE_OVERLAY,
			       MODE_ADD, MODE_SPARE_5, MODE_SPARE_6, MODE_SPARE_7};
		foreach (every_mode[i]) begin
			write_reg(REG_BLEND_MODE, CFG_DATA_BITS'(every_mode[i]));
			send_probes();
			settle();
		end
	endtask

	// Opacity at zero, the smallest step, just under one, and above one
	task automatic test_opacity_range();
		logic [OPACITY_BITS-1:0] levels[5];
		levels = '{'0, 9'd1, OPACITY_ONE - 9'd1, OPACITY_ONE + 9'd1, OPACITY_ALL_ONES};
		write_reg(REG_BLEND_MODE, CFG_DATA_BITS'(MODE_OVERLAY));
		foreach (levels[i]) begin
			write_reg(REG_OPACITY, levels[i]);
			send_pixel('{8'd128, 8'd255, 8'd0, 8'd77, 8'd0, 8'd255, 8'd128});
			settle();
		end
	endtask

	// Spare indexes are ignored; mode keeps only its low bits
	task automatic test_register_decode();
		write_reg(REG_OPACITY, OPACITY_ONE);
		write_reg(REG_BLEND_MODE, {{(CFG_DATA_BITS - MODE_BITS){1'b1}}, MODE_MULTIPLY});
		write_reg(REG_SPARE_LO, '1);
		write_reg(REG_SPARE_HI, '0);
		send_probes();
		settle();
	endtask

	// Hold the output off while words keep coming, so the input stalls
	task automatic test_output_stall();
		write_reg(REG_BLEND_MODE, CFG_DATA_BITS'(MODE_ADD));
		write_reg(REG_OPACITY, OPACITY_ONE >> 1);
		sender_idles = 1'b0;
		hold_request = HOLD_CYCLES;
		repeat (HOLD_WORDS) send_pixel(random_pixel());
		settle();
	endtask

	task automatic test_random_phases();
		logic [OPACITY_BITS-1:0] level;
		for (int unsigned phase = 0; phase < PHASES; phase++) begin
			case (phase % 4)
				0:       level = OPACITY_ONE;
				1:       level = OPACITY_BITS'($urandom());
				2:       level = OPACITY_BITS'($urandom_range(0, OPACITY_ONE));
				default: level = '0;
			endcase
			write_reg(REG_BLEND_MODE,
				  CFG_DATA_BITS'(($urandom() << MODE_BITS) |
						 (phase % (1 << MODE_BITS))));
			write_reg(REG_OPACITY, level);
			write_reg(CFG_INDEX_BITS'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
				  CFG_DATA_BITS'($urandom()));
			// Every third phase runs with no idling on either side
			sender_idles    = (phase % 3 != 0) && ($urandom_range(0, 3) != 0);
			receiver_stalls = (phase % 3 != 0) && ($urandom_range(0, 3) != 0);
			repeat (PHASE_WORDS) send_pixel(random_pixel());
			settle();
		end
	endtask

	// Output side: check each accepted word, then draw the next stall
	always @(posedge clk) begin
		if (arst_n && pix_out.valid && pix_out.ready) begin
			if (predicted_pixels.size() == 0) begin
				$error("output word with nothing expected");
				mismatches++;
			end else begin
				blend_pixel_t want;
				want = predicted_pixels.pop_front();
				compare_field("out_red",   want.red,   pix_out.out_red);
				compare_field("out_green", want.green, pix_out.out_green);
				compare_field("out_blue",  want.blue,  pix_out.out_blue);
				compare_field("out_alpha", want.alpha, pix_out.out_alpha);
			end
			stall_left = receiver_stalls ? $urandom_range(0, MAX_IDLE) : 0;
		end
		if (hold_request != 0) begin
			stall_left = hold_request;
			hold_request = 0;
		end
		if (stall_left != 0) begin
			pix_out.ready <= 1'b0;
			stall_left--;
		end else begin
			pix_out.ready <= 1'b1;
		end
	end

	// Watchdog: end the run if no word moves for too long
	always @(posedge clk) begin
		if (!arst_n || (pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = REG_BLEND_MODE;
		cfg_data          = '0;
		pix_in.valid      = 1'b0;
		pix_in.base_red   = '0;
		pix_in.base_green = '0;
		pix_in.base_blue  = '0;
		pix_in.base_alpha = '0;
		pix_in.over_red   = '0;
		pix_in.over_green = '0;
		pix_in.over_blue  = '0;
		pix_out.ready     = 1'b0;
		mode_copy         = MODE_NORMAL;
		opacity_copy      = OPACITY_ONE;
		mismatches        = 0;
		sender_idles      = 1'b0;
		receiver_stalls   = 1'b0;
		hold_request      = 0;
		stall_left        = 0;
		quiet_cycles      = 0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_blend_modes();
		test_opacity_range();
		test_register_decode();
		test_output_stall();
		test_random_phases();
		settle();

		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/rlb_pkg.sv
rtl/core/rlb_in_if.sv
rtl/core/rlb_out_if.sv
rtl/core/rlb_lane.sv
rtl/core/rgba_layer_blend_core.sv
sim/rgba_layer_blend_core_test.sv
